FILE: hw/rtl/vvps_pkg.sv
// Shared constants, types and arithmetic helpers of the velocity Verlet particle step.
`timescale 1ns / 1ps
`default_nettype none
package vvps_pkg;

  localparam int DW     = 32;          // data word, signed Q16.16
  localparam int FB     = 16;          // fraction bits
  localparam int DTW    = 31;          // width of time step and limit registers
  localparam int IMGW   = 2;           // image step width
  localparam int CFG_AW = 3;           // register index width
  localparam int QW     = DW;          // quotient bits of the scaling divider
  localparam int SQW    = DW;          // root bits of the square root
  localparam int PW     = 2 * DW;      // product width
  localparam int DIVW   = PW + QW;     // divider remainder width

  localparam int IN_W   = 9 * DW;
  localparam int OUT_RAW = 6 * DW + 3 * IMGW;
  localparam int OUT_W  = ((OUT_RAW + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - OUT_RAW;

  // Register indexes of the configuration port.
  localparam logic [CFG_AW-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LIMIT     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BOX_LO_X  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BOX_HI_X  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BOX_LO_Y  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BOX_HI_Y  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_BOX_LO_Z  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_BOX_HI_Z  = 3'd7;

  localparam logic [DTW-1:0] DT_RESET    = 31'd328;
  localparam logic [DTW-1:0] LIMIT_RESET = 31'd0;
  localparam logic [DW-1:0]  BOX_LO_RESET = 32'hFFF0_0000;
  localparam logic [DW-1:0]  BOX_HI_RESET = 32'h0010_0000;

  localparam logic CMD_DRIFT = 1'b0;
  localparam logic CMD_KICK  = 1'b1;

  localparam logic [IMGW-1:0] IMG_ZERO  = 2'b00;
  localparam logic [IMGW-1:0] IMG_PLUS  = 2'b01;
  localparam logic [IMGW-1:0] IMG_MINUS = 2'b11;

  typedef logic [2:0][DW-1:0] vec_t;
  typedef logic [2:0][PW-1:0] pvec_t;

  // Everything an item carries down the pipeline; each stage fills in its part.
  typedef struct packed {
    logic                    cmd;
    logic                    rigid;
    vec_t                    pos;
    vec_t                    vel;
    pvec_t                   prod_a;
    pvec_t                   prod_b;
    vec_t                    kick;
    vec_t                    hv;
    vec_t                    vn;
    vec_t                    x;
    logic [2:0]              neg;
    pvec_t                   num;
    pvec_t                   sq;
    logic [PW-1:0]           s;
    logic [PW-1:0]           l2;
    logic                    gt;
    logic [PW-1:0]           rem;
    logic [PW-1:0]           root;
    logic [PW-1:0]           den;
    logic                    en;
    logic [2:0][DIVW-1:0]    drem;
    vec_t                    quot;
    logic [2:0][IMGW-1:0]    img;
  } carry_t;

  function automatic logic signed [PW-1:0] wide(input logic [DW-1:0] v);
    return {{DW{v[DW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (v > hi) return hi[DW-1:0];
    if (v < lo) return lo[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mul_s(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic signed [PW-1:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic [PW-1:0] mul_u(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [PW-1:0] r;
    r = a * b;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/velocity_verlet_particle_step.sv
// Top level of the pipelined velocity Verlet particle step.
//
// One particle enters as a beat on the s_axis channel: tdata holds position,
// velocity and acceleration, tuser the phase (drift or kick) and the rigid
// flag. Each beat gives exactly one result beat on m_axis with the new
// position, the new velocity and the image steps of the periodic wrap.
// The datapath is a fixed pipeline of 74 register stages, and one beat is
// taken per cycle while no finished result is held up. The length is set
// by the square root (one root bit per stage, 32 stages) and the
// length-limit divider (one quotient bit per stage, 32 stages, three
// lanes side by side).
// When the receiver holds m_axis_tready low while a result waits, the whole
// pipeline freezes and s_axis_tready falls in the same cycle; nothing is
// lost or repeated. Registers are written on the cfg channel, which is
// always ready; write them only while no particle is in flight.
// Reset empties the pipeline and loads dt = 328, limit off and a box of
// -16.0 to +16.0 on each axis.
`timescale 1ns / 1ps
`default_nettype none
module velocity_verlet_particle_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z (low to high)
  input  wire logic [vvps_pkg::IN_W-1:0]     s_axis_tdata,
  // command, in_rigid_body (low to high)
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // new_pos_x/y/z, new_vel_x/y/z, image_step_x/y/z, zero pad (low to high)
  output logic [vvps_pkg::OUT_W-1:0]         m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vvps_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic [vvps_pkg::DW-1:0]       cfg_data_i
);
  import vvps_pkg::*;

  localparam int ST_RT0  = 6;
  localparam int ST_MOVE = ST_RT0 + SQW;
  localparam int ST_DEN  = ST_MOVE + 1;
  localparam int ST_DV0  = ST_DEN + 1;
  localparam int ST_FIX  = ST_DV0 + QW;
  localparam int NSTG    = ST_FIX + 2;

  logic [DTW-1:0]       dt_q;
  logic [DTW-1:0]       limit_q;
  logic [5:0][DW-1:0]   box_q;
  logic [DW-1:0]        dt_w;
  logic [DW-1:0]        limit_w;

  carry_t               c_q [NSTG];
  logic [NSTG-1:0]      vld_q;
  logic                 adv;

  assign dt_w    = {{(DW-DTW){1'b0}}, dt_q};
  assign limit_w = {{(DW-DTW){1'b0}}, limit_q};

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= DT_RESET;
      limit_q <= LIMIT_RESET;
      box_q   <= {BOX_HI_RESET, BOX_LO_RESET, BOX_HI_RESET, BOX_LO_RESET,
                  BOX_HI_RESET, BOX_LO_RESET};
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_TIME_STEP: dt_q     <= cfg_data_i[DTW-1:0];
        REG_LIMIT:     limit_q  <= cfg_data_i[DTW-1:0];
        REG_BOX_LO_X:  box_q[0] <= cfg_data_i;
        REG_BOX_HI_X:  box_q[1] <= cfg_data_i;
        REG_BOX_LO_Y:  box_q[2] <= cfg_data_i;
        REG_BOX_HI_Y:  box_q[3] <= cfg_data_i;
        REG_BOX_LO_Z:  box_q[4] <= cfg_data_i;
        REG_BOX_HI_Z:  box_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole unless a finished result is held up.
  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, c_q[NSTG-1].img, c_q[NSTG-1].vel,
                          c_q[NSTG-1].pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    carry_t cd;

    if (g == 0) begin : g_mul1
      // Products a*dt and v*dt.
      always_comb begin
        vec_t acc;
        acc      = s_axis_tdata[9*DW-1:6*DW];
        cd       = '0;
        cd.cmd   = s_axis_tuser[0];
        cd.rigid = s_axis_tuser[1];
        cd.pos   = s_axis_tdata[3*DW-1:0];
        cd.vel   = s_axis_tdata[6*DW-1:3*DW];
        for (int i = 0; i < 3; i++) begin
          cd.prod_a[i] = mul_s(acc[i], dt_w);
          cd.prod_b[i] = mul_s(cd.vel[i], dt_w);
        end
      end
    end else if (g == 1) begin : g_kick
      // Half kick floor(a*dt/2^(FB+1)) and velocity term, both saturated.
      always_comb begin
        cd = c_q[g-1];
        for (int i = 0; i < 3; i++) begin
          cd.kick[i] = sat($signed(c_q[g-1].prod_a[i]) >>> (FB + 1));
          cd.hv[i]   = sat($signed(c_q[g-1].prod_b[i]) >>> FB);
        end
      end
    end else if (g == 2) begin : g_mul2
      always_comb begin
        cd = c_q[g-1];
        for (int i = 0; i < 3; i++) begin
          cd.prod_a[i] = mul_s(c_q[g-1].kick[i], dt_w);
          cd.vn[i]     = sat(wide(c_q[g-1].vel[i]) + wide(c_q[g-1].kick[i]));
        end
      end
    end else if (g == 3) begin : g_disp
      // Displacement in drift, kicked velocity in kick: the vector to limit.
      always_comb begin
        logic [DW-1:0] d;
        cd = c_q[g-1];
        d  = '0;
        for (int i = 0; i < 3; i++) begin
          d = sat(wide(c_q[g-1].hv[i]) + ($signed(c_q[g-1].prod_a[i]) >>> FB));
          cd.x[i] = (c_q[g-1].cmd == CMD_DRIFT) ? d : c_q[g-1].vn[i];
        end
      end
    end else if (g == 4) begin : g_sq
      always_comb begin
        logic [DW-1:0] mag;
        cd  = c_q[g-1];
        mag = '0;
        for (int i = 0; i < 3; i++) begin
          cd.neg[i] = c_q[g-1].x[i][DW-1];
          mag       = cd.neg[i] ? (~c_q[g-1].x[i] + 1'b1) : c_q[g-1].x[i];
          cd.sq[i]  = mul_u(mag, mag);
          cd.num[i] = mul_u(mag, limit_w);
        end
        cd.l2 = mul_u(limit_w, limit_w);
      end
    end else if (g == 5) begin : g_sum
      always_comb begin
        cd      = c_q[g-1];
        cd.s    = c_q[g-1].sq[0] + c_q[g-1].sq[1] + c_q[g-1].sq[2];
        cd.rem  = cd.s;
        cd.root = '0;
      end
    end else if (g < ST_MOVE) begin : g_root
      // One bit of the integer square root.
      localparam int K = SQW - 1 - (g - ST_RT0);
      always_comb begin
        logic [PW-1:0] bitv;
        logic [PW-1:0] trial;
        cd    = c_q[g-1];
        bitv  = PW'(1) << (2 * K);
        trial = c_q[g-1].root + bitv;
        if (g == ST_RT0) begin
          cd.gt = c_q[g-1].s > c_q[g-1].l2;
        end
        if (c_q[g-1].rem >= trial) begin
          cd.rem  = c_q[g-1].rem - trial;
          cd.root = (c_q[g-1].root >> 1) + bitv;
        end else begin
          cd.root = c_q[g-1].root >> 1;
        end
      end
    end else if (g == ST_MOVE) begin : g_move
      always_comb begin
        cd        = c_q[g-1];
        cd.prod_b = '0;
        cd.prod_b[0] = mul_u(c_q[g-1].root[DW-1:0], dt_w);
      end
    end else if (g == ST_DEN) begin : g_den
      // Divisor and the decision whether the limit acts.
      always_comb begin
        logic [PW-1:0] move;
        cd   = c_q[g-1];
        move = c_q[g-1].prod_b[0] >> FB;
        if (c_q[g-1].cmd == CMD_DRIFT) begin
          cd.den = c_q[g-1].root;
          cd.en  = (limit_q != '0) && c_q[g-1].gt;
        end else begin
          cd.den = move;
          cd.en  = (limit_q != '0) && (move > PW'(limit_q));
        end
        for (int i = 0; i < 3; i++) begin
          cd.drem[i] = {{QW{1'b0}}, c_q[g-1].num[i]};
        end
        cd.quot = '0;
      end
    end else if (g < ST_FIX) begin : g_div
      // One quotient bit of |x|*limit / den on each lane.
      localparam int K = QW - 1 - (g - ST_DV0);
      always_comb begin
        logic [DIVW-1:0] sub;
        cd  = c_q[g-1];
        sub = {{QW{1'b0}}, c_q[g-1].den} << K;
        for (int i = 0; i < 3; i++) begin
          if (c_q[g-1].drem[i] >= sub) begin
            cd.drem[i]    = c_q[g-1].drem[i] - sub;
            cd.quot[i][K] = 1'b1;
          end
        end
      end
    end else if (g == ST_FIX) begin : g_fix
      always_comb begin
        logic [DW-1:0] lim;
        cd     = c_q[g-1];
        cd.img = '{IMG_ZERO, IMG_ZERO, IMG_ZERO};
        lim    = '0;
        for (int i = 0; i < 3; i++) begin
          lim = c_q[g-1].x[i];
          if (c_q[g-1].en) begin
            lim = c_q[g-1].neg[i] ? (~c_q[g-1].quot[i] + 1'b1) : c_q[g-1].quot[i];
          end
          if (!c_q[g-1].rigid) begin
            if (c_q[g-1].cmd == CMD_DRIFT) begin
              cd.pos[i] = sat(wide(c_q[g-1].pos[i]) + wide(lim));
              cd.vel[i] = c_q[g-1].vn[i];
            end else begin
              cd.vel[i] = lim;
            end
          end
        end
      end
    end else begin : g_wrap
      // Single periodic wrap per axis; an empty box does not wrap.
      always_comb begin
        logic signed [PW-1:0] lo;
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] span;
        logic signed [PW-1:0] r;
        cd = c_q[g-1];
        lo = '0; hi = '0; p = '0; span = '0; r = '0;
        for (int i = 0; i < 3; i++) begin
          lo   = wide(box_q[2*i]);
          hi   = wide(box_q[2*i+1]);
          p    = wide(c_q[g-1].pos[i]);
          span = hi - lo;
          if (!c_q[g-1].rigid && c_q[g-1].cmd == CMD_DRIFT && lo < hi) begin
            if (p >= hi) begin
              r          = p - span;
              cd.pos[i]  = r[DW-1:0];
              cd.img[i]  = IMG_PLUS;
            end else if (p < lo) begin
              r          = p + span;
              cd.pos[i]  = r[DW-1:0];
              cd.img[i]  = IMG_MINUS;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_q[g] <= cd;
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/velocity_verlet_particle_step_tb.sv
// Self-checking testbench of the velocity Verlet particle step, with its own predictor.
`timescale 1ns / 1ps
module velocity_verlet_particle_step_tb;
  import vvps_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [DW-1:0]    cfg_data_i = '0;

  velocity_verlet_particle_step dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The predictor's own copy of the register file.
  longint step_dt = 328;
  longint move_limit = 0;
  longint box_bound [6] = '{-1048576, 1048576, -1048576, 1048576, -1048576, 1048576};

  // Particles waiting to be sent, and the updates still owed by the block.
  logic [IN_W-1:0]  particle_q [$];
  logic [1:0]       phase_q [$];
  logic [OUT_W-1:0] update_q [$];

  int  mismatches = 0;
  int  idle_cycles = 0;

  bit  beat_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_mode = 0;
  int  cycle_count = 0;

  function automatic longint clamp_q16(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned norm_sq(longint x, longint y, longint z);
    longint unsigned mx;
    longint unsigned my;
    longint unsigned mz;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    mz = (z < 0) ? -z : z;
    return mx * mx + my * my + mz * mz;
  endfunction

  // Works out the updated particle exactly as the block should.
  function automatic logic [OUT_W-1:0] verlet_update(logic [IN_W-1:0] d, logic [1:0] u);
    longint p [3];
    longint v [3];
    longint a [3];
    longint kick [3];
    longint dsp [3];
    longint img [3];
    longint hv;
    longint lo;
    longint hi;
    longint len;
    longint unsigned s;
    longint unsigned move;
    logic [OUT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(d[i*DW +: DW]);
      v[i] = $signed(d[(3+i)*DW +: DW]);
      a[i] = $signed(d[(6+i)*DW +: DW]);
      img[i] = 0;
    end
    if (!u[1]) begin
      for (int i = 0; i < 3; i++) kick[i] = clamp_q16((a[i] * step_dt) >>> (FB + 1));
      if (u[0] == CMD_DRIFT) begin
        for (int i = 0; i < 3; i++) begin
          hv = clamp_q16((v[i] * step_dt) >>> FB);
          dsp[i] = clamp_q16(hv + ((kick[i] * step_dt) >>> FB));
        end
        if (move_limit != 0) begin
          s = norm_sq(dsp[0], dsp[1], dsp[2]);
          if (s > longint'(move_limit * move_limit)) begin
            len = longint'(floor_root(s));
            for (int i = 0; i < 3; i++) dsp[i] = (dsp[i] * move_limit) / len;
          end
        end
        for (int i = 0; i < 3; i++) begin
          lo = box_bound[2*i];
          hi = box_bound[2*i+1];
          p[i] = clamp_q16(p[i] + dsp[i]);
          v[i] = clamp_q16(v[i] + kick[i]);
          // A single wrap only; an empty box leaves the axis alone.
          if (lo < hi) begin
            if (p[i] >= hi) begin
              p[i] = p[i] - (hi - lo);
              img[i] = 1;
            end else if (p[i] < lo) begin
              p[i] = p[i] + (hi - lo);
              img[i] = -1;
            end
          end
        end
      end else begin
        for (int i = 0; i < 3; i++) v[i] = clamp_q16(v[i] + kick[i]);
        if (move_limit != 0) begin
          move = (floor_root(norm_sq(v[0], v[1], v[2])) * longint'(step_dt)) >> FB;
          if (move > move_limit) begin
            for (int i = 0; i < 3; i++) v[i] = (v[i] * move_limit) / longint'(move);
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r[i*DW +: DW] = p[i][DW-1:0];
      r[(3+i)*DW +: DW] = v[i][DW-1:0];
      r[6*DW + i*IMGW +: IMGW] = img[i][IMGW-1:0];
    end
    return r;
  endfunction

  // Mostly values within +/- spread, with extremes and raw words mixed in.
  function automatic logic [DW-1:0] pick_word(int spread);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: case ($urandom_range(0, 3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0000_0000;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(0, 2 * spread) - spread;
    endcase
  endfunction

  task automatic queue_particle(logic cmd, logic rigid, logic [DW-1:0] px, logic [DW-1:0] py,
                                logic [DW-1:0] pz, logic [DW-1:0] vx, logic [DW-1:0] vy,
                                logic [DW-1:0] vz, logic [DW-1:0] ax, logic [DW-1:0] ay,
                                logic [DW-1:0] az);
    particle_q.push_back({az, ay, ax, vz, vy, vx, pz, py, px});
    phase_q.push_back({rigid, cmd});
  endtask

  task automatic queue_random(int count);
    logic [DW-1:0] w [9];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) w[k] = pick_word(1 << 21);
      for (int k = 3; k < 9; k++) w[k] = pick_word(1 << 18);
      queue_particle($urandom_range(0, 1) ? CMD_KICK : CMD_DRIFT, $urandom_range(0, 7) == 0,
                     w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]);
    end
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [DW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TIME_STEP: step_dt = value[DTW-1:0];
      REG_LIMIT:     move_limit = value[DTW-1:0];
      default:       box_bound[idx - REG_BOX_LO_X] = $signed(value);
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_box(int axis, logic [DW-1:0] lo, logic [DW-1:0] hi);
    write_reg(CFG_AW'(REG_BOX_LO_X + 2 * axis), lo);
    write_reg(CFG_AW'(REG_BOX_HI_X + 2 * axis), hi);
  endtask

  // Waits until every particle is sent and every owed update has come out.
  task automatic drain;
    while (particle_q.size() != 0 || s_axis_tvalid || update_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: a beat stays on the bus until it is taken, then the next one follows after
  // a random gap once the current burst has run out.
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (particle_q.size() != 0) begin
        s_axis_tdata <= particle_q.pop_front();
        s_axis_tuser <= phase_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    // Receiver: ready always, at random, or in a fixed duty pattern.
    cycle_count++;
    if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= (cycle_count % 11) > 3;
    endcase
  end

  // Takes each accepted particle into the predictor and checks each result beat.
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] owed;
    logic [DW-1:0] want;
    logic [DW-1:0] got;
    if (s_axis_tvalid && s_axis_tready) begin
      update_q.push_back(verlet_update(s_axis_tdata, s_axis_tuser));
      beat_taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (update_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        owed = update_q.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (f < 6) begin
            want = owed[f*DW +: DW];
            got = m_axis_tdata[f*DW +: DW];
          end else begin
            want = {30'd0, owed[6*DW + (f-6)*IMGW +: IMGW]};
            got = {30'd0, m_axis_tdata[6*DW + (f-6)*IMGW +: IMGW]};
          end
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d of result: expected %h, got %h", f, want, got);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any beat at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("velocity_verlet_particle_step_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [DW-1:0] r;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed particles under the reset settings.
    queue_particle(CMD_DRIFT, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_particle(CMD_DRIFT, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                   32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    queue_particle(CMD_DRIFT, 1'b0, 32'h000F_FFF0, 32'hFFF0_0001, 32'h0010_0000,
                   32'h0004_0000, 32'hFFFC_0000, 0, 0, 0, 0);
    queue_particle(CMD_KICK, 1'b0, 32'h1234_5678, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_particle(CMD_DRIFT, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0100_0000, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1);
    queue_particle(CMD_KICK, 1'b1, 1, 2, 3, 4, 5, 6, 7, 8, 9);
    queue_random(6);
    drain();

    // Limit on, an empty box along z and a box spanning the whole range along y.
    write_reg(REG_TIME_STEP, 32'h0001_0000);
    write_reg(REG_LIMIT, 32'h0001_0000);
    write_box(0, 32'hFFFF_0000, 32'h0001_0000);
    write_box(1, 32'h8000_0000, 32'h7FFF_FFFF);
    write_box(2, 32'h0001_0000, 32'h0001_0000);
    queue_particle(CMD_DRIFT, 1'b0, 0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
    queue_particle(CMD_DRIFT, 1'b0, 32'h0000_8000, 32'h7FFF_0000, 32'h0002_0000,
                   32'h0000_4000, 32'h0000_4000, 32'h0001_0000, 32'h0001_0000, 0, 0);
    queue_particle(CMD_KICK, 1'b0, 0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0,
                   32'h0002_0000, 0, 0);
    queue_particle(CMD_KICK, 1'b0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_particle(CMD_DRIFT, 1'b0, 32'hFFFE_0000, 32'h8000_0000, 0, 32'hFFFF_0000,
                   32'hFFFF_0000, 0, 0, 0, 0);
    drain();

    // Random phases, each with fresh settings; the first and last use the extremes.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        write_reg(REG_TIME_STEP, 1);
        write_reg(REG_LIMIT, 32'h7FFF_FFFF);
      end else if (ph == 9) begin
        write_reg(REG_TIME_STEP, 32'h7FFF_FFFF);
        write_reg(REG_LIMIT, 1);
      end else begin
        write_reg(REG_TIME_STEP, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h7FFF_FFFF)
                                                             : $urandom_range(1, 1 << 17));
        write_reg(REG_LIMIT, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 12));
      end
      for (int ax = 0; ax < 3; ax++) begin
        case ($urandom_range(0, 5))
          0: write_box(ax, 32'h8000_0000, 32'h7FFF_FFFF);
          1: write_box(ax, $urandom(), $urandom());
          default: begin
            r = $urandom_range(1, 1 << 22);
            write_box(ax, -r, r - $urandom_range(0, 1 << 16));
          end
        endcase
      end
      queue_random(173);
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && update_q.size() == 0) begin
      $display("velocity_verlet_particle_step_tb passed");
    end else begin
      $display("velocity_verlet_particle_step_tb failed");
    end
    $finish;
  end

endmodule

FILE: velocity_verlet_particle_step.f
hw/rtl/vvps_pkg.sv
hw/rtl/velocity_verlet_particle_step.sv
bench/velocity_verlet_particle_step_tb.sv
